FILE: sv/u16u8_pkg.sv
package u16u8_pkg;

  // replacement character for broken surrogates and noncharacters
  localparam logic [7:0] SubChar = 8'h5F;

  // byte-order mark, only dropped as the first unit of a string
  localparam logic [15:0] ByteOrderMark = 16'hFEFF;

  // top six bits of high and low surrogate units
  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;

  // offset of supplementary code points
  localparam logic [20:0] SuppBase = 21'h10000;

  // up to four utf-8 bytes for one request, byte 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            eos;
  } u16u8_burst_t;

  // decoder state carried from one request to the next
  typedef struct packed {
    logic       at_start;
    logic       hi_valid;
    logic [9:0] hi_bits;
  } u16u8_state_t;

endpackage

FILE: sv/u16u8_encode.sv
module u16u8_encode
  import u16u8_pkg::*;
(
  input  logic [15:0]  unit_i,
  input  u16u8_state_t state_i,
  output u16u8_state_t state_o,
  output u16u8_burst_t burst_o
);

  // one code point to 1..4 utf-8 bytes, noncharacters become the sub char
  function automatic u16u8_burst_t encode_cp(input logic [20:0] cp);
    logic [20:0]  c;
    u16u8_burst_t b;
    c = (cp[15:1] == 15'h7FFF) ? {13'd0, SubChar} : cp;
    b = '0;
    if (c <= 21'h7F) begin
      b.bytes[0] = c[7:0];
      b.cnt      = 3'd1;
    end else if (c <= 21'h7FF) begin
      b.bytes[0] = {3'b110, c[10:6]};
      b.bytes[1] = {2'b10, c[5:0]};
      b.cnt      = 3'd2;
    end else if (c <= 21'hFFFF) begin
      b.bytes[0] = {4'b1110, c[15:12]};
      b.bytes[1] = {2'b10, c[11:6]};
      b.bytes[2] = {2'b10, c[5:0]};
      b.cnt      = 3'd3;
    end else begin
      b.bytes[0] = {5'b11110, c[20:18]};
      b.bytes[1] = {2'b10, c[17:12]};
      b.bytes[2] = {2'b10, c[11:6]};
      b.bytes[3] = {2'b10, c[5:0]};
      b.cnt      = 3'd4;
    end
    return b;
  endfunction

  logic        is_zero;
  logic        is_high;
  logic        is_low;
  logic [20:0] pair_cp;

  assign is_zero = (unit_i == 16'h0000);
  assign is_high = (unit_i[15:10] == HighSurrTag);
  assign is_low  = (unit_i[15:10] == LowSurrTag);
  assign pair_cp = {1'b0, state_i.hi_bits, unit_i[9:0]} + SuppBase;

  // decode one unit against the held state
  always_comb begin
    state_o = state_i;
    burst_o = '0;
    if (state_i.hi_valid) begin
      state_o.hi_valid = 1'b0;
      if (is_low) begin
        burst_o = encode_cp(pair_cp);
      end else if (is_zero) begin
        // pair cut by the terminator
        burst_o.bytes[0] = SubChar;
        burst_o.bytes[1] = 8'h00;
        burst_o.cnt      = 3'd2;
        burst_o.eos      = 1'b1;
        state_o.at_start = 1'b1;
      end else begin
        // broken pair, this unit is swallowed
        burst_o.bytes[0] = SubChar;
        burst_o.cnt      = 3'd1;
      end
    end else if (is_zero) begin
      burst_o.bytes[0] = 8'h00;
      burst_o.cnt      = 3'd1;
      burst_o.eos      = 1'b1;
      state_o.at_start = 1'b1;
    end else begin
      state_o.at_start = 1'b0;
      if (state_i.at_start && unit_i == ByteOrderMark) begin
        burst_o.cnt = 3'd0;
      end else if (is_high) begin
        state_o.hi_valid = 1'b1;
        state_o.hi_bits  = unit_i[9:0];
      end else if (is_low) begin
        burst_o.bytes[0] = SubChar;
        burst_o.cnt      = 3'd1;
      end else begin
        burst_o = encode_cp({5'd0, unit_i});
      end
    end
  end

endmodule

FILE: sv/utf16_to_utf8_transcoder.sv
// Converts a stream of UTF-16 code units (one per request, 0x0000 ends a
// string) into UTF-8 bytes, one byte per output request. A leading 0xFEFF is
// dropped, surrogate pairs are joined, and broken surrogates or noncharacters
// come out as '_'. The last byte produced for a unit carries last_of_item_o,
// and the 0x00 terminator also carries end_of_string_o. The output port runs
// at one byte per cycle while out_stall_i is low; a unit gives 1 to 4 bytes,
// and units that give no bytes (a held high surrogate, a dropped BOM) leave
// the input register without waiting for a free result register. Decoding
// sits between an input register and a four-byte result register, so a unit
// is decoded while the previous unit's last byte is still leaving.
module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_item_o,
  output logic        end_of_string_o
);

  logic            in_valid_q;
  logic [15:0]     unit_q;
  u16u8_state_t    state_q;
  u16u8_state_t    state_d;
  u16u8_burst_t    enc_burst;
  logic [3:0][7:0] bytes_q;
  logic [2:0]      cnt_q;
  logic            eos_q;
  logic            out_fire;
  logic            slot_free;
  logic            move;

  // decoder
  u16u8_encode u_encode (
    .unit_i  (unit_q),
    .state_i (state_q),
    .state_o (state_d),
    .burst_o (enc_burst)
  );

  // handshake control
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign slot_free   = !out_valid_o || (out_fire && cnt_q == 3'd1);
  assign move        = in_valid_q && ((enc_burst.cnt == 3'd0) || slot_free);
  assign in_stall_o  = in_valid_q && !move;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      unit_q <= code_unit_i;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{at_start: 1'b1, hi_valid: 1'b0, hi_bits: 10'd0};
    end else if (move) begin
      state_q <= state_d;
    end
  end

  // result register, shifts one byte out per output request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (move && enc_burst.cnt != 3'd0) begin
      cnt_q <= enc_burst.cnt;
    end else if (out_fire) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && enc_burst.cnt != 3'd0) begin
      bytes_q <= enc_burst.bytes;
      eos_q   <= enc_burst.eos;
    end else if (out_fire) begin
      bytes_q <= {8'h00, bytes_q[3:1]};
    end
  end

  // output fields
  assign out_byte_o      = bytes_q[0];
  assign last_of_item_o  = (cnt_q == 3'd1);
  assign end_of_string_o = (cnt_q == 3'd1) && eos_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_string_o |-> out_byte_o == 8'h00)
    else $error("terminator flag on nonzero byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && unit_q == 16'h0000 |=> state_q.at_start && !state_q.hi_valid)
    else $error("terminator did not re-arm string start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && cnt_q != 3'd1 |=> out_valid_o)
    else $error("result burst cut short");

endmodule

FILE: sim/testbench.sv
module testbench
  import u16u8_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // cycles in a row with no request accepted on either side before giving up
  localparam int StallLimit = 2000;
  // cycles waited after the last expected byte, so that stray extra bytes are caught
  localparam int TailCycles = 24;

  typedef struct {
    logic [15:0] unit;
    bit          drain_first;
  } pending_unit_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       eos;
  } utf8_byte_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [15:0] code_unit_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_of_item_o;
  logic        end_of_string_o;

  pending_unit_t unit_queue[$];
  utf8_byte_t    expected_bytes[$];

  // decoder state mirrored from the block
  bit         at_start = 1'b1;
  bit         hi_held  = 1'b0;
  logic [9:0] hi_bits  = '0;

  int  fail_count  = 0;
  int  send_wait   = 0;
  int  recv_wait   = 0;
  bit  send_gappy  = 1'b1;
  bit  recv_gappy  = 1'b1;
  int  quiet_count = 0;
  int  unit_total  = 0;

  utf16_to_utf8_transcoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_unit_i    (code_unit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o),
    .end_of_string_o(end_of_string_o)
  );

  // clock, 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void queue_unit(logic [15:0] u, bit drain = 1'b0);
    pending_unit_t p;
    p.unit        = u;
    p.drain_first = drain;
    unit_queue.push_back(p);
    unit_total++;
  endfunction

  // idle cycles before the next request, with stretches of none at all
  function automatic int draw_gap(inout bit gappy);
    if ($urandom_range(0, 31) == 0) gappy = !gappy;
    return gappy ? int'($urandom_range(0, 4)) : 0;
  endfunction

  function automatic void expect_byte(logic [7:0] data, logic last, logic eos);
    utf8_byte_t b;
    b.data = data;
    b.last = last;
    b.eos  = eos;
    expected_bytes.push_back(b);
  endfunction

  // utf-8 encoding of one code point, noncharacters replaced
  function automatic void expect_code_point(logic [20:0] cp);
    logic [20:0] c;
    c = cp;
    if (c[15:1] == 15'h7FFF) c = {13'b0, SubChar};
    if (c <= 21'h7F) begin
      expect_byte(c[7:0], 1'b1, 1'b0);
    end else if (c <= 21'h7FF) begin
      expect_byte({3'b110, c[10:6]}, 1'b0, 1'b0);
      expect_byte({2'b10, c[5:0]}, 1'b1, 1'b0);
    end else if (c <= 21'hFFFF) begin
      expect_byte({4'b1110, c[15:12]}, 1'b0, 1'b0);
      expect_byte({2'b10, c[11:6]}, 1'b0, 1'b0);
      expect_byte({2'b10, c[5:0]}, 1'b1, 1'b0);
    end else begin
      expect_byte({5'b11110, c[20:18]}, 1'b0, 1'b0);
      expect_byte({2'b10, c[17:12]}, 1'b0, 1'b0);
      expect_byte({2'b10, c[11:6]}, 1'b0, 1'b0);
      expect_byte({2'b10, c[5:0]}, 1'b1, 1'b0);
    end
  endfunction

  // bytes that one accepted code unit should produce
  function automatic void transcode_unit(logic [15:0] u);
    if (hi_held) begin
      hi_held = 1'b0;
      if (u[15:10] == LowSurrTag) begin
        expect_code_point({1'b0, hi_bits, u[9:0]} + SuppBase);
      end else if (u == '0) begin
        // pair cut short by the terminator
        expect_byte(SubChar, 1'b0, 1'b0);
        expect_byte(8'h00, 1'b1, 1'b1);
        at_start = 1'b1;
      end else begin
        // broken pair, the following unit is swallowed
        expect_byte(SubChar, 1'b1, 1'b0);
      end
    end else if (u == '0) begin
      expect_byte(8'h00, 1'b1, 1'b1);
      at_start = 1'b1;
    end else if (at_start && u == ByteOrderMark) begin
      at_start = 1'b0;
    end else begin
      at_start = 1'b0;
      if (u[15:10] == HighSurrTag) begin
        hi_bits = u[9:0];
        hi_held = 1'b1;
      end else if (u[15:10] == LowSurrTag) begin
        expect_byte(SubChar, 1'b1, 1'b0);
      end else begin
        expect_code_point({5'b0, u});
      end
    end
  endfunction

  // one random element of a string, sometimes more than one unit
  function automatic void queue_random_element();
    case ($urandom_range(0, 11))
      0, 1, 2: queue_unit(16'($urandom_range(1, 16'h7F)));
      3:       queue_unit(16'($urandom_range(16'h80, 16'h7FF)));
      4:       queue_unit(16'($urandom_range(16'h800, 16'hD7FF)));
      5:       queue_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
      6, 7, 8: begin
        queue_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        queue_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
      9:       queue_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
      10: begin
        queue_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        queue_unit(16'($urandom()));
      end
      default: queue_unit(($urandom_range(0, 1) != 0) ? 16'hFFFE : 16'hFFFF);
    endcase
  endfunction

  // stimulus, reset and end of run
  initial begin
    int len;

    // empty string, bom only, bom then a later bom
    queue_unit(16'h0000);
    queue_unit(16'hFEFF);
    queue_unit(16'h0000);
    queue_unit(16'hFEFF);
    queue_unit(16'h0041);
    queue_unit(16'hFEFF);
    // encoding length boundaries and noncharacters
    queue_unit(16'h007F);
    queue_unit(16'h0080);
    queue_unit(16'h07FF);
    queue_unit(16'h0800);
    queue_unit(16'hD7FF);
    queue_unit(16'hE000);
    queue_unit(16'hFFFE);
    queue_unit(16'hFFFF);
    // lowest and highest pairs, the highest being a noncharacter
    queue_unit(16'hD800);
    queue_unit(16'hDC00);
    queue_unit(16'hDBFF);
    queue_unit(16'hDFFF);
    // lone low half, broken pairs, pair cut by terminator
    queue_unit(16'hDC00);
    queue_unit(16'hD800);
    queue_unit(16'h0041);
    queue_unit(16'hD800);
    queue_unit(16'hD800);
    queue_unit(16'hDBFF);
    queue_unit(16'h0000);

    // random strings, mostly well formed
    while (unit_total < 320) begin
      if ($urandom_range(0, 3) == 0) queue_unit(ByteOrderMark, $urandom_range(0, 9) == 0);
      len = $urandom_range(0, 10);
      for (int i = 0; i < len; i++) queue_random_element();
      queue_unit(16'h0000, $urandom_range(0, 15) == 0);
    end
    // hold the sender once right after the directed part
    unit_queue[25].drain_first = 1'b1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (unit_queue.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      code_unit_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        transcode_unit(code_unit_i);
        send_wait = draw_gap(send_gappy);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (unit_queue.size() != 0 &&
                     !(unit_queue[0].drain_first && expected_bytes.size() != 0)) begin
          in_valid_i  <= 1'b1;
          code_unit_i <= unit_queue[0].unit;
          void'(unit_queue.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // byte monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected byte %h last %b eos %b", out_byte_o, last_of_item_o,
                     end_of_string_o);
        end else begin
          if (out_byte_o !== expected_bytes[0].data ||
              last_of_item_o !== expected_bytes[0].last ||
              end_of_string_o !== expected_bytes[0].eos) begin
            fail_count++;
            if (fail_count <= 10)
              $display("byte mismatch: expected %h/%b/%b got %h/%b/%b",
                       expected_bytes[0].data, expected_bytes[0].last,
                       expected_bytes[0].eos, out_byte_o, last_of_item_o,
                       end_of_string_o);
          end
          void'(expected_bytes.pop_front());
        end
        recv_wait = draw_gap(recv_gappy);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
      end
      if (quiet_count >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
